FILE: rtl/upt_pkg.sv
// ----------------------------------------------------------------------------
// upt_pkg : shared definitions for the upgrade packet tracker
// Field widths, request/response layouts, function and status codes.
// ----------------------------------------------------------------------------
package upt_pkg;

   // sizing
   localparam int unsigned MAX_PACKETS  = 4096;
   localparam int unsigned MAX_PAYLOAD  = 200;
   localparam int unsigned MAX_REPORTED = 51;

   // field widths
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned SPACE_W  = 24;
   localparam int unsigned IMAGE_W  = 24;
   localparam int unsigned PSIZE_W  = 8;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned PLEN_W   = 8;

   // bitmap geometry
   localparam int unsigned WORD_W       = 32;
   localparam int unsigned BIT_W        = 5;
   localparam int unsigned BITMAP_WORDS = (MAX_PACKETS + WORD_W - 1) / WORD_W;
   localparam int unsigned ROW_W        = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int unsigned CNT_W        = $clog2(MAX_PACKETS + 1);
   localparam int unsigned CMP_W        = (ID_W > CNT_W) ? ID_W : CNT_W;
   localparam int unsigned MUL_W        = ID_W + PSIZE_W;
   localparam int unsigned FOUND_W      = $clog2(MAX_REPORTED + 1);
   localparam int unsigned DIV_STEP_W   = $clog2(IMAGE_W);

   // packet size must be a multiple of four
   localparam logic [PSIZE_W-1:0] ALIGN_MASK = 8'h03;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_APP_BASE_ADDR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_APP_SPACE_SIZE = 1'd1;

   // request kinds (carried on tuser)
   localparam logic [FUNC_W-1:0] FUNC_PREPARE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PACKET  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd3;

   // response status (carried on tuser)
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_WRONG_TARGET = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REJECTED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_WRITE_FAILED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_MISSING      = 3'd6;

   // tdata layouts, first field in the lowest bits
   localparam int unsigned REQ_FIELDS_W = 1 + IMAGE_W + PSIZE_W + ID_W + PLEN_W + 1;
   localparam int unsigned REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_W = 2 + ADDR_W + IMAGE_W + ID_W;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic [REQ_DATA_W-REQ_FIELDS_W-1:0] pad;
      logic                               write_ok;
      logic [PLEN_W-1:0]                  payload_length;
      logic [ID_W-1:0]                    packet_id;
      logic [PSIZE_W-1:0]                 packet_bytes;
      logic [IMAGE_W-1:0]                 image_size;
      logic                               target_is_app;
   } upt_req_data_type;

   typedef struct packed {
      logic [RSP_DATA_W-RSP_FIELDS_W-1:0] pad;
      logic [ID_W-1:0]                    missing_id;
      logic [IMAGE_W-1:0]                 flash_length;
      logic [ADDR_W-1:0]                  flash_addr;
      logic                               write_request;
      logic                               erase_request;
   } upt_rsp_data_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic               done;
      logic [IMAGE_W-1:0] quotient;
      logic               rem_nz;
   } upt_div_res_type;

endpackage

FILE: rtl/upt_ram.sv
// ----------------------------------------------------------------------------
// upt_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while idle.
// ----------------------------------------------------------------------------
module upt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/upt_div.sv
// ----------------------------------------------------------------------------
// upt_div : restoring divider, one quotient bit per cycle
// Image size over packet size; reports quotient and a non-zero remainder flag.
// ----------------------------------------------------------------------------
module upt_div
   import upt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [IMAGE_W-1:0] dividend,
   input  logic [PSIZE_W-1:0] divisor,   // held stable while busy
   output upt_div_res_type    result
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [IMAGE_W-1:0]    work_ff, work_in;   // dividend out at top, quotient in at bottom
   logic [PSIZE_W-1:0]    rem_ff, rem_in;

   logic [PSIZE_W:0]      rem_sh;
   logic [PSIZE_W+1:0]    diff;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[IMAGE_W-1]};
      diff    = {1'b0, rem_sh} - (PSIZE_W + 2)'(divisor);
      ge      = ~diff[PSIZE_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         work_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         work_in = {work_ff[IMAGE_W-2:0], ge};
         rem_in  = ge ? diff[PSIZE_W-1:0] : rem_sh[PSIZE_W-1:0];
         step_in = step_ff + DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(IMAGE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = work_ff;
   assign result.rem_nz   = |rem_ff;

endmodule

FILE: rtl/upgrade_packet_tracker.sv
// ----------------------------------------------------------------------------
// upgrade_packet_tracker : receive bitmap for a firmware image sent in packets
// Validates a prepare request, tracks written packets in a bitmap RAM,
// issues erase/write requests and lists missing packet ids on demand.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  req     | in        | req_tvalid/req_tready | tuser = func, tdata = item fields
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser = status, tdata, tlast
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data (always ready)
//
//  One request at a time; req_tready is high only while the sequencer is idle.
//  Packet: decode and bitmap RAM read, held-bit test and offset multiply, address
//  add, emit; an already held packet skips the add. Write result: bitmap RAM read-modify-write.
//  Prepare: waits on the 24-step restoring divider.
//  Check: walks the ids, reading each bitmap word as it is reached and
//  emitting each reported id. The response register frees the sequencer: the
//  next request is taken while the last response still waits, and rsp_tready
//  stalls only stop the sequencer when a further response has to be loaded.
//  Synchronous active-high reset clears control state and the row-valid flags;
//  the bitmap RAM itself needs no clearing pass.
//
module upgrade_packet_tracker
   import upt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // target_is_app, image_size, packet_bytes, packet_id, payload_length, write_ok
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [FUNC_W-1:0]     req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // erase_request, write_request, flash_addr, flash_length, missing_id
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [STATUS_W-1:0]   rsp_tuser,
   output logic                  rsp_tlast,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_DIV       = 4'd2;
   localparam logic [3:0] S_PKT_RD    = 4'd3;
   localparam logic [3:0] S_PKT_ADD   = 4'd4;
   localparam logic [3:0] S_WR_RD     = 4'd5;
   localparam logic [3:0] S_CHK_RD    = 4'd6;
   localparam logic [3:0] S_CHK_BIT   = 4'd7;
   localparam logic [3:0] S_CHK_FINAL = 4'd8;
   localparam logic [3:0] S_EMIT      = 4'd9;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      upt_rsp_data_type    data;
      logic                last;
   } res_type;

   // single-result response with nothing but a status
   function automatic res_type short_res(input logic [STATUS_W-1:0] status);
      res_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   function automatic res_type missing_res(input logic [CNT_W-1:0] id, input logic last);
      res_type r;
      r                 = '0;
      r.status          = ST_MISSING;
      r.data.missing_id = ID_W'(id);
      r.last            = last;
      return r;
   endfunction

   // registers
   logic [3:0]             state_ff, state_in;
   logic [3:0]             ret_ff, ret_in;
   res_type                res_ff, res_in;
   res_type                rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   upt_req_data_type       item_ff;
   logic [FUNC_W-1:0]      func_ff;
   logic [ADDR_W-1:0]      cfg_base_ff;
   logic [SPACE_W-1:0]     cfg_space_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PSIZE_W-1:0]     psize_ff, psize_in;
   logic [BITMAP_WORDS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [FOUND_W-1:0]     found_ff, found_in;
   logic                   pend_ff, pend_in;
   logic [CNT_W-1:0]       pend_id_ff, pend_id_in;
   logic [WORD_W-1:0]      word_ff, word_in;
   logic [MUL_W-1:0]       mul_ff, mul_in;
   logic [ROW_W-1:0]       rd_row_ff, rd_row_in;

   // combinational
   upt_req_data_type       req_item;
   logic                   req_accept;
   logic                   out_free;
   logic                   ram_rd_en, ram_wr_en;
   logic [ROW_W-1:0]       ram_rd_addr, ram_wr_addr;
   logic [WORD_W-1:0]      ram_wr_data, ram_rd_data;
   logic [WORD_W-1:0]      read_word;
   logic [ROW_W-1:0]       id_row;
   logic                   id_out_of_range;
   logic                   div_start;
   upt_div_res_type        div_res;
   logic [CNT_W-1:0]       scan_next;
   logic [3:0]             scan_after;
   logic                   too_large;

   assign req_item   = upt_req_data_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign csr_ready  = 1'b1;

   assign id_row          = item_ff.packet_id[ROW_W+BIT_W-1:BIT_W];
   assign id_out_of_range = CMP_W'(item_ff.packet_id) >= CMP_W'(count_ff);
   // rows not written since the last prepare read as all zero
   assign read_word       = valid_ff[rd_row_ff] ? ram_rd_data : '0;
   assign scan_next       = scan_ff + CNT_W'(1);
   assign too_large       = (div_res.quotient > IMAGE_W'(MAX_PACKETS)) ||
                            ((div_res.quotient == IMAGE_W'(MAX_PACKETS)) && div_res.rem_nz);

   upt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (item_ff.image_size),
      .divisor  (item_ff.packet_bytes),
      .result   (div_res)
   );

   upt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BITMAP_WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      psize_in     = psize_ff;
      valid_in     = valid_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      word_in      = word_ff;
      mul_in       = mul_ff;
      rd_row_in    = rd_row_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = id_row;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = rd_row_ff;
      ram_wr_data  = read_word | (WORD_W'(1) << item_ff.packet_id[BIT_W-1:0]);
      div_start    = 1'b0;
      scan_after   = S_CHK_BIT;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            ret_in = S_IDLE;
            case (func_ff)
               FUNC_PREPARE: begin
                  if (!item_ff.target_is_app) begin
                     res_in   = short_res(ST_WRONG_TARGET);
                     state_in = S_EMIT;
                  end else if ((item_ff.packet_bytes == '0) ||
                               ((item_ff.packet_bytes & ALIGN_MASK) != '0)) begin
                     res_in   = short_res(ST_MISALIGNED);
                     state_in = S_EMIT;
                  end else if (item_ff.image_size > cfg_space_ff) begin
                     res_in   = short_res(ST_TOO_LARGE);
                     state_in = S_EMIT;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               FUNC_PACKET: begin
                  if (id_out_of_range || (item_ff.payload_length > PLEN_W'(MAX_PAYLOAD))) begin
                     res_in   = short_res(ST_REJECTED);
                     state_in = S_EMIT;
                  end else begin
                     ram_rd_en = 1'b1;
                     rd_row_in = id_row;
                     state_in  = S_PKT_RD;
                  end
               end
               FUNC_WRITE: begin
                  if (id_out_of_range) begin
                     res_in   = short_res(ST_REJECTED);
                     state_in = S_EMIT;
                  end else if (!item_ff.write_ok) begin
                     res_in   = short_res(ST_WRITE_FAILED);
                     state_in = S_EMIT;
                  end else begin
                     ram_rd_en = 1'b1;
                     rd_row_in = id_row;
                     state_in  = S_WR_RD;
                  end
               end
               default: begin
                  // check: walk the bitmap from id 0
                  if (count_ff == '0) begin
                     res_in   = short_res(ST_OK);
                     state_in = S_EMIT;
                  end else begin
                     scan_in     = '0;
                     found_in    = '0;
                     pend_in     = 1'b0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     rd_row_in   = '0;
                     state_in    = S_CHK_RD;
                  end
               end
            endcase
         end

         S_DIV: begin
            if (div_res.done) begin
               ret_in   = S_IDLE;
               state_in = S_EMIT;
               if (too_large) begin
                  res_in = short_res(ST_TOO_LARGE);
               end else begin
                  count_in                 = CNT_W'(div_res.quotient) + CNT_W'(div_res.rem_nz);
                  psize_in                 = item_ff.packet_bytes;
                  valid_in                 = '0;
                  res_in                   = short_res(ST_OK);
                  res_in.data.erase_request = 1'b1;
                  res_in.data.flash_addr   = cfg_base_ff;
                  res_in.data.flash_length = item_ff.image_size;
               end
            end
         end

         S_PKT_RD: begin
            ret_in = S_IDLE;
            if (read_word[item_ff.packet_id[BIT_W-1:0]]) begin
               // already held: accept quietly
               res_in   = short_res(ST_OK);
               state_in = S_EMIT;
            end else begin
               mul_in   = MUL_W'(item_ff.packet_id) * MUL_W'(psize_ff);
               state_in = S_PKT_ADD;
            end
         end

         S_PKT_ADD: begin
            res_in                    = short_res(ST_OK);
            res_in.data.write_request = 1'b1;
            res_in.data.flash_addr    = cfg_base_ff + ADDR_W'(mul_ff);
            res_in.data.flash_length  = IMAGE_W'(item_ff.payload_length);
            ret_in                    = S_IDLE;
            state_in                  = S_EMIT;
         end

         S_WR_RD: begin
            ram_wr_en           = 1'b1;
            valid_in[rd_row_ff] = 1'b1;
            res_in              = short_res(ST_OK);
            ret_in              = S_IDLE;
            state_in            = S_EMIT;
         end

         S_CHK_RD: begin
            word_in  = read_word;
            state_in = S_CHK_BIT;
         end

         S_CHK_BIT: begin
            if (scan_ff >= count_ff) begin
               // end of the image: flush the held id, or report all present
               res_in   = pend_ff ? missing_res(pend_id_ff, 1'b1) : short_res(ST_OK);
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end else begin
               scan_in = scan_next;
               if (scan_next[BIT_W-1:0] == '0) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = scan_next[ROW_W+BIT_W-1:BIT_W];
                  rd_row_in   = scan_next[ROW_W+BIT_W-1:BIT_W];
                  scan_after  = S_CHK_RD;
               end
               state_in = scan_after;
               if (!word_ff[scan_ff[BIT_W-1:0]]) begin
                  // one id is held back so the final one can carry tlast
                  found_in   = found_ff + FOUND_W'(1);
                  pend_in    = 1'b1;
                  pend_id_in = scan_ff;
                  if (found_ff == FOUND_W'(MAX_REPORTED - 1)) begin
                     state_in = S_EMIT;
                     if (pend_ff) begin
                        res_in = missing_res(pend_id_ff, 1'b0);
                        ret_in = S_CHK_FINAL;
                     end else begin
                        res_in = missing_res(scan_ff, 1'b1);
                        ret_in = S_IDLE;
                     end
                  end else if (pend_ff) begin
                     res_in   = missing_res(pend_id_ff, 1'b0);
                     ret_in   = scan_after;
                     state_in = S_EMIT;
                  end
               end
            end
         end

         S_CHK_FINAL: begin
            res_in   = missing_res(pend_id_ff, 1'b1);
            ret_in   = S_IDLE;
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               state_in = ret_ff;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == S_EMIT) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_base_ff  <= '0;
         cfg_space_ff <= '0;
         count_ff     <= '0;
         psize_ff     <= '0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         psize_ff     <= psize_in;
         valid_ff     <= valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_APP_BASE_ADDR:  cfg_base_ff  <= ADDR_W'(csr_data);
               CSR_APP_SPACE_SIZE: cfg_space_ff <= SPACE_W'(csr_data);
               default: begin
               end
            endcase
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      ret_ff     <= ret_in;
      res_ff     <= res_in;
      scan_ff    <= scan_in;
      found_ff   <= found_in;
      pend_ff    <= pend_in;
      pend_id_ff <= pend_id_in;
      word_ff    <= word_in;
      mul_ff     <= mul_in;
      rd_row_ff  <= rd_row_in;
      if (req_accept) begin
         item_ff <= req_item;
         func_ff <= req_tuser;
      end
      if ((state_ff == S_EMIT) && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.data;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   upt_rsp_data_type rsp_view;
   assign rsp_view = upt_rsp_data_type'(rsp_tdata);

   // only a missing-id listing spreads over several responses
   ap_nonlast_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == ST_MISSING)
      else $error("non-final response without missing status");

   // a response never asks for both erase and write
   ap_one_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_view.erase_request && rsp_view.write_request))
      else $error("erase and write requested together");

   // write requests only for packets within the payload limit
   ap_write_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.write_request |-> rsp_view.flash_length <= IMAGE_W'(MAX_PAYLOAD))
      else $error("write request longer than the payload limit");

   // the divider only finishes while a prepare waits on it
   ap_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == S_DIV)
      else $error("divider finished outside a prepare");

endmodule

FILE: tb/sv/upgrade_packet_tracker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// upgrade_packet_tracker_test : self-checking bench for the packet tracker
// Drives prepare, packet, write-result and check requests and writes both
// registers over several settings. A scoreboard keeps its own bitmap, packet
// count and packet size, predicts every response and compares each one
// field by field. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
import upt_pkg::*;

typedef struct {
   logic [STATUS_W-1:0] status;
   logic                erase;
   logic                write;
   logic [ADDR_W-1:0]   addr;
   logic [IMAGE_W-1:0]  length;
   logic [ID_W-1:0]     missing;
   logic                last;
} tracker_result_type;

class tracker_scoreboard;
   logic [ADDR_W-1:0]      base_addr;
   logic [SPACE_W-1:0]     space_size;
   int unsigned            pkt_count;
   logic [PSIZE_W-1:0]     pkt_size;
   logic [MAX_PACKETS-1:0] held;
   tracker_result_type     due_results[$];
   int                     errors;

   function new();
      base_addr  = '0;
      space_size = '0;
      pkt_count  = 0;
      pkt_size   = '0;
      held       = '0;
      errors     = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_APP_BASE_ADDR:  base_addr  = value;
         CSR_APP_SPACE_SIZE: space_size = value[SPACE_W-1:0];
         default: ;
      endcase
   endfunction

   function void queue_result(logic [STATUS_W-1:0] status, logic erase, logic write,
                              logic [ADDR_W-1:0] addr, logic [IMAGE_W-1:0] length,
                              logic [ID_W-1:0] missing, logic last);
      tracker_result_type r;
      r.status  = status;
      r.erase   = erase;
      r.write   = write;
      r.addr    = addr;
      r.length  = length;
      r.missing = missing;
      r.last    = last;
      due_results.push_back(r);
   endfunction

   // predict the responses of one accepted request and update the state
   function void note_request(logic [FUNC_W-1:0] func, upt_req_data_type d);
      int unsigned       count;
      int unsigned       gaps[$];
      logic [ADDR_W-1:0] offset;
      case (func)
         FUNC_PREPARE: begin
            if (!d.target_is_app)
               queue_result(ST_WRONG_TARGET, 0, 0, 0, 0, 0, 1);
            else if (d.packet_bytes == 0 || (d.packet_bytes & ALIGN_MASK) != 0)
               queue_result(ST_MISALIGNED, 0, 0, 0, 0, 0, 1);
            else if (d.image_size > space_size)
               queue_result(ST_TOO_LARGE, 0, 0, 0, 0, 0, 1);
            else begin
               count = (32'(d.image_size) + 32'(d.packet_bytes) - 32'd1)
                       / 32'(d.packet_bytes);
               if (count > MAX_PACKETS)
                  queue_result(ST_TOO_LARGE, 0, 0, 0, 0, 0, 1);
               else begin
                  pkt_count = count;
                  pkt_size  = d.packet_bytes;
                  held      = '0;
                  queue_result(ST_OK, 1, 0, base_addr, d.image_size, 0, 1);
               end
            end
         end
         FUNC_PACKET: begin
            if (d.packet_id >= pkt_count || d.payload_length > MAX_PAYLOAD)
               queue_result(ST_REJECTED, 0, 0, 0, 0, 0, 1);
            else if (held[d.packet_id])
               queue_result(ST_OK, 0, 0, 0, 0, 0, 1);
            else begin
               offset = d.packet_id;
               offset = offset * pkt_size;
               queue_result(ST_OK, 0, 1, offset + base_addr,
                            IMAGE_W'(d.payload_length), 0, 1);
            end
         end
         FUNC_WRITE: begin
            if (d.packet_id >= pkt_count)
               queue_result(ST_REJECTED, 0, 0, 0, 0, 0, 1);
            else if (d.write_ok) begin
               held[d.packet_id] = 1'b1;
               queue_result(ST_OK, 0, 0, 0, 0, 0, 1);
            end else
               queue_result(ST_WRITE_FAILED, 0, 0, 0, 0, 0, 1);
         end
         FUNC_CHECK: begin
            for (int unsigned i = 0; i < pkt_count && gaps.size() < MAX_REPORTED; i++)
               if (!held[i]) gaps.push_back(i);
            if (gaps.size() == 0)
               queue_result(ST_OK, 0, 0, 0, 0, 0, 1);
            else
               foreach (gaps[k])
                  queue_result(ST_MISSING, 0, 0, 0, 0, ID_W'(gaps[k]),
                               k == gaps.size() - 1);
         end
      endcase
   endfunction

   function void compare(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endfunction

   function void check_response(logic [STATUS_W-1:0] status, upt_rsp_data_type d,
                                logic last);
      tracker_result_type want;
      if (due_results.size() == 0) begin
         errors++;
         $display("%0t: response with none expected, actual status %0d tdata %h last %b",
                  $time, status, d, last);
         return;
      end
      want = due_results.pop_front();
      compare("status", want.status, status);
      compare("erase_request", want.erase, d.erase_request);
      compare("write_request", want.write, d.write_request);
      compare("flash_addr", want.addr, d.flash_addr);
      compare("flash_length", want.length, d.flash_length);
      compare("missing_id", want.missing, d.missing_id);
      compare("last", want.last, last);
   endfunction
endclass

module upgrade_packet_tracker_test;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [FUNC_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   tracker_scoreboard sb = new();

   // idling odds in percent, changed per phase
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   // walks through the ids so that sessions actually fill up
   int unsigned next_write_id      = 0;

   upgrade_packet_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: ready decided at the falling edge, response taken at the rising
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   function automatic upt_req_data_type pack_fields(logic target, logic [IMAGE_W-1:0] isize,
                                                    logic [PSIZE_W-1:0] pbytes,
                                                    logic [ID_W-1:0] id,
                                                    logic [PLEN_W-1:0] plen, logic wok);
      upt_req_data_type f;
      f                = '0;
      f.target_is_app  = target;
      f.image_size     = isize;
      f.packet_bytes   = pbytes;
      f.packet_id      = id;
      f.payload_length = plen;
      f.write_ok       = wok;
      return f;
   endfunction

   // Enters and leaves at a falling edge. tvalid is left high on return so that
   // a following request needs no drop and re-raise in the same step; idle()
   // lowers it when the stream pauses.
   task automatic send_request(input logic [FUNC_W-1:0] func, input upt_req_data_type f);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(func, f);
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding response
   task automatic idle();
      req_tvalid <= 1'b0;
      while (sb.due_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // both registers, back to back; call only while the block is idle, the task itself does not enforce it
   task automatic configure(input logic [CSR_DATA_W-1:0] base,
                            input logic [CSR_DATA_W-1:0] space);
      csr_valid <= 1'b1;
      csr_index <= CSR_APP_BASE_ADDR;
      csr_data  <= base;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(CSR_APP_BASE_ADDR, base);
      @(negedge clock);
      csr_index <= CSR_APP_SPACE_SIZE;
      csr_data  <= space;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(CSR_APP_SPACE_SIZE, space);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed traffic for the current session: prepares that pass,
   // packets and write results with ids in range, the odd check. The rest is
   // broken prepares, out-of-range ids, long payloads and random kinds.
   // Unused fields always carry random bits.
   task automatic send_random_item();
      upt_req_data_type  f;
      int unsigned       pick;
      int unsigned       cnt;
      int unsigned       pbytes;
      int unsigned       isize;
      logic [FUNC_W-1:0] kind;
      f       = '0;
      f.target_is_app  = 1'($urandom_range(1));
      f.image_size     = IMAGE_W'($urandom);
      f.packet_bytes   = PSIZE_W'($urandom);
      f.packet_id      = ID_W'($urandom);
      f.payload_length = PLEN_W'($urandom);
      f.write_ok       = 1'($urandom_range(1));
      pick = $urandom_range(99);
      // no session open yet: usually start one
      if (sb.pkt_count == 0 && pick < 70) pick = 0;
      if (pick < 7) begin
         if ($urandom_range(3) != 0) begin
            cnt    = ($urandom_range(9) == 0) ? $urandom_range(MAX_PACKETS, 1)
                                              : $urandom_range(40, 1);
            pbytes = 4 * $urandom_range(63, 1);
            isize  = (cnt - 1) * pbytes + $urandom_range(pbytes, 1);
            if (isize > sb.space_size) isize = sb.space_size;
            f.target_is_app = 1'b1;
            f.packet_bytes  = PSIZE_W'(pbytes);
            f.image_size    = IMAGE_W'(isize);
            next_write_id   = 0;
         end
         send_request(FUNC_PREPARE, f);
      end else if (pick < 50) begin
         if (sb.pkt_count != 0 && $urandom_range(9) != 0)
            f.packet_id = ID_W'($urandom_range(sb.pkt_count - 1));
         if ($urandom_range(9) != 0)
            f.payload_length = PLEN_W'($urandom_range(MAX_PAYLOAD));
         send_request(FUNC_PACKET, f);
      end else if (pick < 85) begin
         if (sb.pkt_count != 0 && $urandom_range(9) != 0) begin
            if ($urandom_range(1)) begin
               f.packet_id = ID_W'(next_write_id % sb.pkt_count);
               next_write_id++;
            end else
               f.packet_id = ID_W'($urandom_range(sb.pkt_count - 1));
         end
         f.write_ok = ($urandom_range(99) < 85);
         send_request(FUNC_WRITE, f);
      end else if (pick < 93) begin
         send_request(FUNC_CHECK, f);
      end else begin
         kind = FUNC_W'($urandom_range(3));
         send_request(kind, f);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_PREPARE;
      csr_valid  = 1'b0;
      csr_index  = CSR_APP_BASE_ADDR;
      csr_data   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // registers still at reset: no session, no space
      send_request(FUNC_CHECK, pack_fields(0, 0, 0, 0, 0, 0));
      send_request(FUNC_PACKET, pack_fields(0, 0, 0, 0, 0, 0));
      send_request(FUNC_WRITE, pack_fields(0, 0, 0, 0, 0, 1));
      send_request(FUNC_PREPARE, pack_fields(1, 4, 4, 0, 0, 0));
      idle();

      // base near the top so that write addresses wrap, full space
      configure(32'hFFFF_FF00, 32'h00FF_FFFF);
      send_request(FUNC_PREPARE, pack_fields(0, 100, 4, 0, 0, 0));
      send_request(FUNC_PREPARE, pack_fields(1, 100, 0, 0, 0, 0));
      send_request(FUNC_PREPARE, pack_fields(1, 100, 255, 0, 0, 0));
      // fits the space but far too many packets
      send_request(FUNC_PREPARE, pack_fields(1, 24'hFF_FFFF, 4, 0, 0, 0));
      // one packet over the limit, then exactly at it
      send_request(FUNC_PREPARE, pack_fields(1, 4096 * 252 + 1, 252, 0, 0, 0));
      send_request(FUNC_PREPARE, pack_fields(1, 4096 * 252, 252, 0, 0, 0));
      send_request(FUNC_PACKET, pack_fields(0, 0, 0, 4095, 200, 0));
      send_request(FUNC_PACKET, pack_fields(0, 0, 0, 4096, 0, 0));
      send_request(FUNC_PACKET, pack_fields(0, 0, 0, 0, 201, 0));
      send_request(FUNC_WRITE, pack_fields(0, 0, 0, 4095, 0, 1));
      send_request(FUNC_WRITE, pack_fields(0, 0, 0, 0, 0, 0));
      send_request(FUNC_WRITE, pack_fields(0, 0, 0, 16'hFFFF, 0, 1));
      // already held: accepted without a write
      send_request(FUNC_PACKET, pack_fields(0, 0, 0, 4095, 10, 0));
      send_request(FUNC_PACKET, pack_fields(0, 0, 0, 1, 255, 0));
      // most ids missing: the list is cut short
      send_request(FUNC_CHECK, pack_fields(0, 0, 0, 0, 0, 0));
      // empty image, nothing can be missing
      send_request(FUNC_PREPARE, pack_fields(1, 0, 4, 0, 0, 0));
      send_request(FUNC_CHECK, pack_fields(0, 0, 0, 0, 0, 0));
      // three packets, all written
      send_request(FUNC_PREPARE, pack_fields(1, 10, 4, 0, 0, 0));
      send_request(FUNC_WRITE, pack_fields(0, 0, 0, 0, 0, 1));
      send_request(FUNC_WRITE, pack_fields(0, 0, 0, 1, 0, 1));
      send_request(FUNC_WRITE, pack_fields(0, 0, 0, 2, 0, 1));
      send_request(FUNC_CHECK, pack_fields(0, 0, 0, 0, 0, 0));
      idle();

      // image just over and just at a small space
      configure(32'h0, 32'd1000);
      send_request(FUNC_PREPARE, pack_fields(1, 1001, 252, 0, 0, 0));
      send_request(FUNC_PREPARE, pack_fields(1, 1000, 252, 0, 0, 0));
      idle();

      // random phases: no idling, sender gaps, receiver stalls, both lightly
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
               configure(32'h0, 32'h00FF_FFFF);
            end
            1: begin
               sender_idle_pct    = 77;
               receiver_stall_pct = 0;
               configure($urandom, $urandom);
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 77;
               configure(32'hFFFF_FFFF, $urandom);
            end
            default: begin
               sender_idle_pct    = 11;
               receiver_stall_pct = 11;
               configure($urandom, 32'hFFFF_FFFF);
            end
         endcase
         repeat (71) send_random_item();
         idle();
      end

      if (sb.errors == 0 && sb.due_results.size() == 0)
         $display("upgrade_packet_tracker regression: pass");
      else
         $display("upgrade_packet_tracker regression: fail");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("upgrade_packet_tracker regression: fail");
      $finish;
   end

endmodule
